[src/rft_pkg.sv]
package rft_pkg;

  localparam int SignalWidth   = 16;
  localparam int AmpWidth      = 15;
  localparam int BetaWidth     = 16;
  localparam int BetaFrac      = 14;
  localparam int HoldWidth     = 16;
  localparam int CountWidth    = 10;
  localparam int CmdWidth      = 16;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;
  localparam int ProdWidth     = BetaWidth + SignalWidth;
  localparam int CmpWidth      = ProdWidth + 1;

  localparam logic [AmpWidth-1:0]  AmpReset  = AmpWidth'(4096);
  localparam logic [HoldWidth-1:0] ElapsedMax = '1;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_ENABLE  = 2'd2,
    KIND_DISABLE = 2'd3
  } kind_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_BETA      = 2'd1,
    REG_HOLD      = 2'd2,
    REG_CONFIRM   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [AmpWidth-1:0]          amplitude;
    logic signed [BetaWidth-1:0]  beta;
    logic [HoldWidth-1:0]         hold;
    logic [CountWidth-1:0]        confirm;
  } cfg_t;

  typedef struct packed {
    logic                          enabled;
    logic                          first_sample;
    logic                          output_negative;
    logic signed [SignalWidth-1:0] peak_high;
    logic signed [SignalWidth-1:0] peak_low;
    logic                          reached_high;
    logic                          reached_low;
    logic [CountWidth-1:0]         confirm_counter;
    logic [HoldWidth-1:0]          elapsed_ms;
  } state_t;

endpackage

[src/rft_in_if.sv]
interface rft_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic signed [rft_pkg::SignalWidth-1:0] error_value;

  modport source (output valid, kind, error_value, input ready);
  modport sink (input valid, kind, error_value, output ready);
endinterface

[src/rft_out_if.sv]
interface rft_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rft_pkg::CmdWidth-1:0] command;
  logic                                switched;

  modport source (output valid, command, switched, input ready);
  modport sink (input valid, command, switched, output ready);
endinterface

[src/rft_step.sv]
module rft_step (
  input  rft_pkg::state_t                     st,
  input  rft_pkg::cfg_t                       cfg,
  input  rft_pkg::kind_t                      kind,
  input  logic signed [rft_pkg::SignalWidth-1:0] err,
  output rft_pkg::state_t                     st_next,
  output logic                                has_result,
  output logic signed [rft_pkg::CmdWidth-1:0] command,
  output logic                                switched
);

  logic                                      new_low;
  logic                                      new_high;
  logic signed [rft_pkg::SignalWidth-1:0]    peak_sel;
  logic signed [rft_pkg::ProdWidth-1:0]      prod;
  logic signed [rft_pkg::CmpWidth-1:0]       err_ext;
  logic signed [rft_pkg::CmpWidth-1:0]       lhs;
  logic signed [rft_pkg::CmpWidth-1:0]       rhs;
  logic [rft_pkg::CountWidth:0]              cnt_inc;
  logic                                      hit;
  logic signed [rft_pkg::CmdWidth-1:0]       amp_s;

  assign new_low  = err < st.peak_low;
  assign new_high = err > st.peak_high;

  // threshold uses the peak as updated by this sample
  assign peak_sel = st.output_negative ? (new_low ? err : st.peak_low)
                                       : (new_high ? err : st.peak_high);
  assign prod     = cfg.beta * peak_sel;
  assign err_ext  = rft_pkg::CmpWidth'(err);
  assign lhs      = err_ext <<< rft_pkg::BetaFrac;
  assign rhs      = -(rft_pkg::CmpWidth'(prod));

  assign cnt_inc = {1'b0, st.confirm_counter} + 1'b1;
  assign hit     = cnt_inc >= {1'b0, cfg.confirm};
  assign amp_s   = signed'({1'b0, cfg.amplitude});

  always_comb begin
    st_next    = st;
    has_result = 1'b0;
    switched   = 1'b0;
    unique case (kind)
      rft_pkg::KIND_TICK: begin
        if (st.elapsed_ms != rft_pkg::ElapsedMax) begin
          st_next.elapsed_ms = st.elapsed_ms + 1'b1;
        end
      end
      rft_pkg::KIND_ENABLE: begin
        st_next.enabled         = 1'b1;
        st_next.first_sample    = 1'b1;
        st_next.output_negative = 1'b0;
        st_next.peak_high       = '0;
        st_next.peak_low        = '0;
        st_next.reached_high    = 1'b0;
        st_next.reached_low     = 1'b0;
        st_next.confirm_counter = '0;
      end
      rft_pkg::KIND_DISABLE: begin
        st_next.enabled = 1'b0;
      end
      rft_pkg::KIND_SAMPLE: begin
        has_result = 1'b1;
        if (!st.enabled) begin
          st_next = st;
        end else if (st.first_sample) begin
          st_next.first_sample    = 1'b0;
          st_next.elapsed_ms      = '0;
          st_next.confirm_counter = '0;
          st_next.peak_high       = '0;
          st_next.peak_low        = '0;
          st_next.reached_high    = err > 0;
          st_next.reached_low     = !(err > 0);
          st_next.output_negative = !(err > 0);
        end else if (st.elapsed_ms <= cfg.hold) begin
          st_next = st;
        end else if (st.output_negative) begin
          if (new_low) begin
            st_next.peak_low        = err;
            st_next.confirm_counter = '0;
          end else begin
            if (hit) begin
              st_next.reached_low     = 1'b1;
              st_next.confirm_counter = '0;
            end else begin
              st_next.confirm_counter = cnt_inc[rft_pkg::CountWidth-1:0];
            end
            st_next.peak_high = err;
          end
          if (st_next.reached_low && (lhs > rhs)) begin
            st_next.output_negative = 1'b0;
            st_next.elapsed_ms      = '0;
            st_next.reached_low     = 1'b0;
            switched                = 1'b1;
          end
        end else begin
          if (new_high) begin
            st_next.peak_high       = err;
            st_next.confirm_counter = '0;
          end else begin
            if (hit) begin
              st_next.reached_high    = 1'b1;
              st_next.confirm_counter = '0;
            end else begin
              st_next.confirm_counter = cnt_inc[rft_pkg::CountWidth-1:0];
            end
            st_next.peak_low = err;
          end
          if (st_next.reached_high && (lhs < rhs)) begin
            st_next.output_negative = 1'b1;
            st_next.elapsed_ms      = '0;
            st_next.reached_high    = 1'b0;
            switched                = 1'b1;
          end
        end
      end
      default: st_next = st;
    endcase
  end

  always_comb begin
    if (!st_next.enabled) begin
      command = '0;
    end else if (st_next.output_negative) begin
      command = -amp_s;
    end else begin
      command = amp_s;
    end
  end

endmodule

[src/relay_feedback_tuner.sv]
// latency: a sample transfer shows its result in the next cycle on the output register
// throughput: one item per cycle while no result waits unread; the state update is a
// single pass with one 16x16 multiply and compare between the input and the state
// registers; ticks, enables and disables give no result and are taken at that rate
// reset: synchronous, active high; drive disabled, configuration back to defaults
module relay_feedback_tuner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rft_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [rft_pkg::CfgDataWidth-1:0]     cfg_data,
  rft_in_if.sink                               in_item,
  rft_out_if.source                            out_item
);

  rft_pkg::cfg_t                        cfg;
  rft_pkg::state_t                      st;
  rft_pkg::state_t                      st_next;
  logic                                 in_xfer;
  logic                                 has_result;
  logic signed [rft_pkg::CmdWidth-1:0]  command_next;
  logic                                 switched_next;
  logic                                 out_valid;
  logic signed [rft_pkg::CmdWidth-1:0]  command;
  logic                                 switched;

  assign in_item.ready = !out_valid || out_item.ready;
  assign in_xfer       = in_item.valid && in_item.ready;

  rft_step u_step (
    .st         (st),
    .cfg        (cfg),
    .kind       (rft_pkg::kind_t'(in_item.kind)),
    .err        (in_item.error_value),
    .st_next    (st_next),
    .has_result (has_result),
    .command    (command_next),
    .switched   (switched_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amplitude <= rft_pkg::AmpReset;
      cfg.beta      <= '0;
      cfg.hold      <= '0;
      cfg.confirm   <= '0;
    end else if (cfg_we) begin
      unique case (rft_pkg::cfg_index_t'(cfg_index))
        rft_pkg::REG_AMPLITUDE: cfg.amplitude <= cfg_data[rft_pkg::AmpWidth-1:0];
        rft_pkg::REG_BETA:      cfg.beta      <= signed'(cfg_data[rft_pkg::BetaWidth-1:0]);
        rft_pkg::REG_HOLD:      cfg.hold      <= cfg_data[rft_pkg::HoldWidth-1:0];
        rft_pkg::REG_CONFIRM:   cfg.confirm   <= cfg_data[rft_pkg::CountWidth-1:0];
        default:                cfg.confirm   <= cfg.confirm;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.enabled         <= 1'b0;
      st.first_sample    <= 1'b1;
      st.output_negative <= 1'b0;
      st.peak_high       <= '0;
      st.peak_low        <= '0;
      st.reached_high    <= 1'b0;
      st.reached_low     <= 1'b0;
      st.confirm_counter <= '0;
      st.elapsed_ms      <= '0;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && has_result) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && has_result) begin
      command  <= command_next;
      switched <= switched_next;
    end
  end

  assign out_item.valid    = out_valid;
  assign out_item.command  = command;
  assign out_item.switched = switched;

  a_switch_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> st.enabled && !st.first_sample && st.elapsed_ms == '0)
    else $error("switch result without matching relay state");

  a_command_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != '0 |-> command[rft_pkg::CmdWidth-1] == st.output_negative)
    else $error("command sign differs from relay sign");

  a_enable_restart: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_item.kind == rft_pkg::KIND_ENABLE
      |=> st.enabled && st.first_sample && st.confirm_counter == '0)
    else $error("enable did not restart the relay");

  a_no_result_stall: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !has_result && !out_item.ready |=> out_valid == $past(out_valid))
    else $error("output valid changed on an item without result");

endmodule
